// ----- hdl/srlp_pkg.sv -----
// Shared types, codes and helper functions of the S-record line parser.
package srlp_pkg;

  // Configuration register indexes and reset values.
  localparam logic RegMinLineChars = 1'b0;
  localparam logic RegMaxDataBytes = 1'b1;
  localparam logic [7:0] MinLineCharsReset = 8'd10;
  localparam logic [7:0] MaxDataBytesReset = 8'd64;

  // Character constants used while parsing.
  localparam logic [7:0] CharS = 8'h53;
  localparam logic [7:0] CharTwo = 8'h32;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharSix = 8'h36;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharEight = 8'h38;
  localparam logic [9:0] PosMax = 10'd1023;
  localparam logic [2:0] AddrBytesReset = 3'd2;

  // Result kinds.
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_RECORD = 1'b1
  } kind_e;

  // Record status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_S      = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_BAD_HEX   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  // Configuration values handed from the register block to the parser.
  typedef struct packed {
    logic [7:0] min_line_chars;
    logic [7:0] max_data_bytes;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  record_type;
    logic [31:0] load_address;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    status_e     status;
  } result_t;

  // Hex digit decode: bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- hdl/srecord_line_parser_unit.sv -----
// Top level of the S-record line parser.
//
// The slave stream carries one character of an S-record line per transaction;
// tlast marks the end of the line, and the character of that transaction is
// not used. The master stream carries results: a data byte result for each
// decoded data byte, and one end of record result with the status when the
// line ends. Characters that produce no result leave no transaction.
// A result is in the output register the cycle after its character is
// accepted. Throughput is one character per cycle while the output register
// can load; the line state registers update on each accepted character.
// When the receiver stalls, the output register holds its transaction and
// s_axis_tready falls until the result is taken; no character is lost.
// Reset clears the line state, empties the output register and loads the
// configuration registers with their defaults (minimum line length 10,
// at most 64 data bytes). The user writes configuration over the APB port
// only while the stream is idle; the block itself does not enforce this.
module srecord_line_parser_unit
  import srlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_line
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] record_type, [39:8] load_address, [47:40] byte_index,
  // [55:48] data_byte, [58:56] status, [63:59] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] kind
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  srlp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srlp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .char_i      (s_axis_tdata),
    .eol_i       (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srlp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  // Pack the result fields onto the stream.
  assign m_axis_tdata = {5'd0, out_res.status, out_res.data_byte, out_res.byte_index,
                         out_res.load_address, out_res.record_type};
  assign m_axis_tuser = out_res.kind;

endmodule

// ----- hdl/srlp_apb_regs.sv -----
// APB configuration registers of the S-record line parser.
module srlp_apb_regs
  import srlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [7:0] min_q, min_d;
  logic [7:0] max_q, max_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; the word address selects the register.
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegMinLineChars: min_d = pwdata[7:0];
        RegMaxDataBytes: max_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinLineCharsReset;
      max_q <= MaxDataBytesReset;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (paddr[2])
      RegMinLineChars: prdata = {24'd0, min_q};
      RegMaxDataBytes: prdata = {24'd0, max_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.min_line_chars = min_q;
  assign cfg_o.max_data_bytes = max_q;

endmodule

// ----- hdl/srlp_parse_core.sv -----
// Per-character line state and result generation of the S-record parser.
module srlp_parse_core
  import srlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       eol_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [9:0]  pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;
  logic [2:0]  abytes_q, abytes_d;
  logic [31:0] addr_q, addr_d;
  logic [3:0]  high_q, high_d;
  logic [7:0]  bcnt_q, bcnt_d;
  logic [7:0]  sum_q, sum_d;
  status_e     err_q, err_d;
  logic        seen_q, seen_d;
  logic        csok_q, csok_d;

  logic [9:0]  pos_m2;
  logic [8:0]  pair;
  logic        odd;
  logic        cnt_ok;
  logic        parsed;
  logic [7:0]  data_len;
  logic [4:0]  hex;
  logic [3:0]  nib;
  logic [7:0]  v;
  status_e     rec_status;

  // Byte position within the hex part of the line.
  assign pos_m2 = pos_q - 10'd2;
  assign pair   = pos_m2[9:1];
  assign odd    = pos_m2[0];

  // The count covers address, data and checksum; data length follows.
  assign cnt_ok   = count_q >= ({5'd0, abytes_q} + 8'd1);
  assign data_len = cnt_ok ? (count_q - {5'd0, abytes_q} - 8'd1) : 8'd0;
  assign parsed   = (pair <= {6'd0, abytes_q}) || (cnt_ok && (pair <= {1'b0, count_q}));

  // Nibble of this character; a bad digit counts as zero.
  assign hex = hex_decode(char_i);
  assign nib = hex[4] ? 4'd0 : hex[3:0];
  assign v   = {high_q, nib};

  // Record status, highest priority first.
  always_comb begin
    priority if (pos_q == 10'd0 || err_q == ST_NO_S) begin
      rec_status = ST_NO_S;
    end else if (pos_q <= {2'd0, cfg_i.min_line_chars} || !seen_q) begin
      rec_status = ST_TOO_SHORT;
    end else if (err_q == ST_BAD_HEX) begin
      rec_status = ST_BAD_HEX;
    end else if (data_len > cfg_i.max_data_bytes) begin
      rec_status = ST_OVERFLOW;
    end else if (csok_q) begin
      rec_status = ST_OK;
    end else begin
      rec_status = ST_CHECKSUM;
    end
  end

  // Next line state and the result of this transaction.
  always_comb begin
    pos_d    = pos_q;
    type_d   = type_q;
    count_d  = count_q;
    abytes_d = abytes_q;
    addr_d   = addr_q;
    high_d   = high_q;
    bcnt_d   = bcnt_q;
    sum_d    = sum_q;
    err_d    = err_q;
    seen_d   = seen_q;
    csok_d   = csok_q;

    res_valid_o        = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.record_type  = type_q;
    res_o.load_address = addr_q;
    res_o.byte_index   = bcnt_q;
    res_o.data_byte    = v;
    res_o.status       = ST_OK;

    if (accept_i) begin
      if (eol_i) begin
        // End of line: report the record and clear for the next line.
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_RECORD;
        res_o.data_byte = 8'd0;
        res_o.status    = rec_status;
        pos_d    = 10'd0;
        type_d   = 8'd0;
        count_d  = 8'd0;
        abytes_d = AddrBytesReset;
        addr_d   = 32'd0;
        high_d   = 4'd0;
        bcnt_d   = 8'd0;
        sum_d    = 8'd0;
        err_d    = ST_OK;
        seen_d   = 1'b0;
        csok_d   = 1'b0;
      end else begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + 10'd1;
        end
        if (pos_q == 10'd0) begin
          // Start character.
          if (char_i != CharS && err_q == ST_OK) begin
            err_d = ST_NO_S;
          end
        end else if (pos_q == 10'd1) begin
          // Record type selects the address width.
          type_d = char_i;
          if (char_i == CharTwo || char_i == CharSix || char_i == CharEight) begin
            abytes_d = 3'd3;
          end else if (char_i == CharThree || char_i == CharSeven) begin
            abytes_d = 3'd4;
          end else begin
            abytes_d = 3'd2;
          end
        end else if (parsed) begin
          if (hex[4] && err_q == ST_OK) begin
            err_d = ST_BAD_HEX;
          end
          if (!odd) begin
            high_d = nib;
          end else if (pair == 9'd0) begin
            count_d = v;
            sum_d   = sum_q + v;
          end else if (pair <= {6'd0, abytes_q}) begin
            addr_d = {addr_q[23:0], v};
            sum_d  = sum_q + v;
          end else if (pair < {1'b0, count_q}) begin
            res_valid_o = 1'b1;
            bcnt_d      = bcnt_q + 8'd1;
            sum_d       = sum_q + v;
          end else begin
            seen_d = 1'b1;
            csok_d = (~sum_q == v);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 10'd0;
      type_q   <= 8'd0;
      count_q  <= 8'd0;
      abytes_q <= AddrBytesReset;
      addr_q   <= 32'd0;
      high_q   <= 4'd0;
      bcnt_q   <= 8'd0;
      sum_q    <= 8'd0;
      err_q    <= ST_OK;
      seen_q   <= 1'b0;
      csok_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      type_q   <= type_d;
      count_q  <= count_d;
      abytes_q <= abytes_d;
      addr_q   <= addr_d;
      high_q   <= high_d;
      bcnt_q   <= bcnt_d;
      sum_q    <= sum_d;
      err_q    <= err_d;
      seen_q   <= seen_d;
      csok_q   <= csok_d;
    end
  end

endmodule

// ----- hdl/srlp_out_stage.sv -----
// Output register of the S-record parser; holds one result transaction.
module srlp_out_stage
  import srlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_ready_i
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can load when empty or when its transaction leaves now.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/srlp_checker.sv -----
// Port-level assertions of the S-record line parser and their binding.
module srlp_checker
  import srlp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Every line end produces a record result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
    else $error("line end gave no record result");

  // Data byte results always carry an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[58:56] == ST_OK)
    else $error("data result with nonzero status");

  // Record results carry a zero data byte and a defined status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[55:48] == 8'd0
      && m_axis_tdata[58:56] <= ST_OVERFLOW)
    else $error("malformed record result");

endmodule

bind srecord_line_parser_unit srlp_checker u_srlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/srlp_result_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the S-record parser's result transactions and compares them.
module srlp_result_checker
  import srlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character stream
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_line
  // Result stream
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] record_type, [39:8] load_address, [47:40] byte_index,
  // [55:48] data_byte, [58:56] status, [63:59] zero
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tuser,   // [0] kind
  // Configuration port, watched for register writes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_o,
  output int          fail_count_o
);

  // Our copy of the configuration registers.
  logic [7:0]  min_chars_q;
  logic [7:0]  max_bytes_q;

  // Line state of the parser as we expect it.
  logic [9:0]  line_pos;
  logic [7:0]  type_char;
  logic [7:0]  count_val;
  logic [2:0]  addr_len;
  logic [31:0] addr_val;
  logic [3:0]  hi_nib;
  logic [7:0]  data_count;
  logic [7:0]  sum_q;
  status_e     line_err;
  logic        cs_seen;
  logic        cs_ok;

  // Results still owed by the parser, oldest first.
  result_t     owed_results[$];
  result_t     want;
  int          n_fail = 0;

  assign fail_count_o = n_fail;

  // Nibble value of a hex character, or 16 for anything else.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    return 16;
  endfunction

  // Data bytes that the count field announces; zero when the count is too small.
  function automatic int announced_data_len();
    if (int'(count_val) < int'(addr_len) + 1) return 0;
    return int'(count_val) - int'(addr_len) - 1;
  endfunction

  task automatic clear_line();
    line_pos   = '0;
    type_char  = '0;
    count_val  = '0;
    addr_len   = AddrBytesReset;
    addr_val   = '0;
    hi_nib     = '0;
    data_count = '0;
    sum_q      = '0;
    line_err   = ST_OK;
    cs_seen    = 1'b0;
    cs_ok      = 1'b0;
  endtask

  // Advances the line state by one character and queues any result it causes.
  task automatic predict_char(input logic [7:0] c, input logic eol);
    int         p;
    int         h;
    int         b;
    int         a;
    int         dlen;
    int         nib;
    logic [7:0] v;
    logic [7:0] inv_sum;
    result_t    r;
    p    = int'(line_pos);
    a    = int'(addr_len);
    dlen = announced_data_len();
    r    = '0;
    if (eol) begin
      // End of line: status by priority, then a fresh line.
      r.kind         = KIND_RECORD;
      r.record_type  = type_char;
      r.load_address = addr_val;
      r.byte_index   = data_count;
      r.data_byte    = '0;
      if (p == 0 || line_err == ST_NO_S) begin
        r.status = ST_NO_S;
      end else if (p <= int'(min_chars_q) || !cs_seen) begin
        r.status = ST_TOO_SHORT;
      end else if (line_err == ST_BAD_HEX) begin
        r.status = ST_BAD_HEX;
      end else if (dlen > int'(max_bytes_q)) begin
        r.status = ST_OVERFLOW;
      end else begin
        r.status = cs_ok ? ST_OK : ST_CHECKSUM;
      end
      owed_results.push_back(r);
      clear_line();
    end else begin
      if (line_pos < PosMax) line_pos++;
      if (p == 0) begin
        if (c != CharS && line_err == ST_OK) line_err = ST_NO_S;
      end else if (p == 1) begin
        type_char = c;
        if (c inside {CharTwo, CharSix, CharEight}) begin
          addr_len = 3'd3;
        end else if (c inside {CharThree, CharSeven}) begin
          addr_len = 3'd4;
        end else begin
          addr_len = AddrBytesReset;
        end
      end else begin
        h = p - 2;
        b = h >> 1;
        // Count and address are always parsed; data and checksum only if announced.
        if (b <= a || (int'(count_val) >= a + 1 && b <= a + dlen + 1)) begin
          nib = hex_nibble(c);
          if (nib > 15) begin
            if (line_err == ST_OK) line_err = ST_BAD_HEX;
            nib = 0;
          end
          if ((h & 1) == 0) begin
            hi_nib = nib[3:0];
          end else begin
            v = {hi_nib, nib[3:0]};
            if (b == 0) begin
              count_val = v;
              sum_q     = sum_q + v;
            end else if (b <= a) begin
              addr_val = {addr_val[23:0], v};
              sum_q    = sum_q + v;
            end else if (b <= a + dlen) begin
              r.kind         = KIND_DATA;
              r.record_type  = type_char;
              r.load_address = addr_val;
              r.byte_index   = data_count;
              r.data_byte    = v;
              r.status       = ST_OK;
              owed_results.push_back(r);
              data_count = data_count + 8'd1;
              sum_q      = sum_q + v;
            end else begin
              inv_sum = ~sum_q;
              cs_seen = 1'b1;
              cs_ok   = (inv_sum == v);
            end
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("result field %s: expected %0h, actual %0h", name, exp_val, act_val);
      n_fail++;
    end
  endtask

  // Compares one accepted result transaction with the oldest owed result.
  task automatic compare_result();
    if (owed_results.size() == 0) begin
      $error("result transaction with none expected: tdata %h tuser %b",
             m_axis_tdata, m_axis_tuser);
      n_fail++;
    end else begin
      want = owed_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
      check_field("record_type", 32'(want.record_type), 32'(m_axis_tdata[7:0]));
      check_field("load_address", want.load_address, m_axis_tdata[39:8]);
      check_field("byte_index", 32'(want.byte_index), 32'(m_axis_tdata[47:40]));
      check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[55:48]));
      check_field("status", 32'(want.status), 32'(m_axis_tdata[58:56]));
      check_field("padding", 32'd0, 32'(m_axis_tdata[63:59]));
    end
  endtask

  // Watch all three ports at each clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_chars_q = MinLineCharsReset;
      max_bytes_q = MaxDataBytesReset;
      clear_line();
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == RegMinLineChars) begin
          min_chars_q = pwdata[7:0];
        end else begin
          max_bytes_q = pwdata[7:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) predict_char(s_axis_tdata, s_axis_tlast);
      pending_o <= owed_results.size();
    end
  end

endmodule

// ----- tb/sv/tb_srecord_line_parser_unit.sv -----
`timescale 1ns / 100ps
// Testbench top of the S-record line parser: clock, reset, stimulus and verdict.
module tb_srecord_line_parser_unit;
  import srlp_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseChars = 60;
  localparam int LongHold   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_in
  logic        s_axis_tlast;   // end_of_line
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] record_type, [39:8] load_address, [47:40] byte_index,
  // [55:48] data_byte, [58:56] status, [63:59] zero
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;   // [0] kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          fail_count;
  int          chars_sent = 0;
  int          cycle_count = 0;
  logic        sender_gaps = 1'b0;
  logic        hold_go = 1'b0;
  logic [7:0]  line_chars[$];

  always #5 clk_i = ~clk_i;

  srecord_line_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  srlp_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result receiver: ready stretches, short and long stalls, and one long hold-off.
  initial begin : receiver
    int   r;
    logic held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (r < 45) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else if (r < 92) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(8, 40)) @(posedge clk_i);
      end
    end
  end

  function automatic int addr_len_of(input logic [7:0] rtype);
    if (rtype inside {CharTwo, CharSix, CharEight}) return 3;
    if (rtype inside {CharThree, CharSeven}) return 4;
    return 2;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  // Characters that are never hex digits, several right beside the digit ranges.
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 8))
      0: return 8'h00;
      1: return 8'h2F;
      2: return 8'h3A;
      3: return 8'h40;
      4: return 8'h47;
      5: return 8'h60;
      6: return 8'h67;
      7: return 8'hFF;
      default: return 8'h80 | 8'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic push_hex(input logic [7:0] v, input logic mixed);
    line_chars.push_back(hex_char(v[7:4], mixed && $urandom_range(0, 1)));
    line_chars.push_back(hex_char(v[3:0], mixed && $urandom_range(0, 1)));
  endtask

  // Builds a record line with random data; a count of -1 means the correct count.
  task automatic build_record(input logic [7:0] rtype, input logic [31:0] addr,
                              input int ndata, input int count_force,
                              input logic [7:0] csum_flip, input logic mixed);
    int         alen;
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] d;
    alen = addr_len_of(rtype);
    cnt  = (count_force >= 0) ? 8'(count_force) : 8'(alen + ndata + 1);
    line_chars.delete();
    line_chars.push_back("S");
    line_chars.push_back(rtype);
    push_hex(cnt, mixed);
    sum = cnt;
    for (int i = alen - 1; i >= 0; i--) begin
      d = addr[8*i +: 8];
      push_hex(d, mixed);
      sum = sum + d;
    end
    for (int i = 0; i < ndata; i++) begin
      d = 8'($urandom_range(0, 255));
      push_hex(d, mixed);
      sum = sum + d;
    end
    push_hex(~sum ^ csum_flip, mixed);
  endtask

  task automatic add_trailing(input int n);
    repeat (n) line_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Offers one character transaction and waits until it is taken.
  task automatic send_item(input logic [7:0] c, input logic eol);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    r = $urandom_range(0, 99);
    if (sender_gaps && r >= 55) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk_i);
      else repeat ($urandom_range(8, 40)) @(posedge clk_i);
    end
  endtask

  task automatic send_line();
    sender_gaps = ($urandom_range(0, 3) != 0);
    foreach (line_chars[i]) send_item(line_chars[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Lowers valid and waits until every owed result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Empty line.
    line_chars.delete();
    send_line();
    // Good records of each address width, extreme addresses, both letter cases.
    build_record("1", 32'h0000_0000, 1, -1, 8'h00, 1'b0);
    send_line();
    build_record(CharTwo, 32'h00FF_FFFF, 2, -1, 8'h00, 1'b1);
    send_line();
    build_record(CharThree, 32'hFFFF_FFFF, 1, -1, 8'h00, 1'b1);
    send_line();
    build_record(CharSeven, 32'h1234_5678, 0, -1, 8'h00, 1'b0);
    send_line();
    build_record(CharEight, 32'h00AB_CDEF, 0, -1, 8'h00, 1'b1);
    send_line();
    build_record(CharSix, 32'h0, 0, -1, 8'h00, 1'b0);
    send_line();
    // Exactly the minimum length is still too short.
    build_record("9", 32'h0, 0, -1, 8'h00, 1'b0);
    send_line();
    // Data at the limit, then one byte over it.
    build_record("5", 32'hBEEF, 64, -1, 8'h00, 1'b1);
    send_line();
    build_record("0", 32'h1, 65, -1, 8'h00, 1'b1);
    send_line();
    // Missing S.
    build_record("1", 32'h55AA, 2, -1, 8'h00, 1'b0);
    line_chars[0] = "s";
    send_line();
    // Checksum off by one bit.
    build_record("1", 32'h1000, 3, -1, 8'h01, 1'b0);
    send_line();
    // Bad hex in data, in the address and in the count.
    build_record("1", 32'h2000, 3, -1, 8'h00, 1'b0);
    line_chars[8] = "G";
    send_line();
    build_record(CharThree, 32'h3000, 1, -1, 8'h00, 1'b0);
    line_chars[5] = 8'hFF;
    send_line();
    build_record("1", 32'h4000, 1, -1, 8'h00, 1'b0);
    line_chars[2] = 8'h3A;
    send_line();
    // Count too small for the address.
    build_record("1", 32'h5000, 2, 2, 8'h00, 1'b0);
    send_line();
    build_record(CharThree, 32'h6000, 0, 0, 8'h00, 1'b0);
    send_line();
    // Line ends before the checksum is complete.
    build_record("1", 32'h7000, 4, -1, 8'h00, 1'b0);
    repeat (3) void'(line_chars.pop_back());
    send_line();
    // Trailing characters after the checksum.
    build_record("1", 32'h8000, 2, -1, 8'h00, 1'b0);
    line_chars.push_back("Z");
    line_chars.push_back(8'hFF);
    line_chars.push_back(8'h00);
    send_line();
    // Only the S.
    line_chars.delete();
    line_chars.push_back("S");
    send_line();
  endtask

  // One random line: mostly well-formed records, the rest broken or noise.
  task automatic random_line();
    int         r;
    int         k;
    int         nd;
    int         alen;
    int         cnt;
    logic [7:0] rtype;
    logic [7:0] flip;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r >= 94) begin
      line_chars.delete();
      add_trailing($urandom_range(0, 30));
      if (line_chars.size() > 0 && $urandom_range(0, 1)) line_chars[0] = "S";
      send_line();
      return;
    end
    if ($urandom_range(0, 9) != 0) rtype = 8'("0") + 8'($urandom_range(0, 9));
    else rtype = 8'($urandom_range(0, 255));
    alen = addr_len_of(rtype);
    k = $urandom_range(0, 99);
    if (k < 85) nd = $urandom_range(0, 16);
    else if (k < 97) nd = $urandom_range(17, 80);
    else nd = $urandom_range(81, 254 - alen);
    cnt  = (r >= 84 && r < 90) ? $urandom_range(0, alen) : -1;
    flip = (r >= 78 && r < 84) ? 8'($urandom_range(1, 255)) : 8'h00;
    build_record(rtype, $urandom, nd, cnt, flip, 1'($urandom_range(0, 1)));
    if (r >= 60 && r < 66) begin
      do c = 8'($urandom_range(0, 255)); while (c == CharS);
      line_chars[0] = c;
    end else if (r >= 66 && r < 72) begin
      line_chars[$urandom_range(2, line_chars.size() - 1)] = non_hex_char();
    end else if (r >= 72 && r < 78) begin
      repeat ($urandom_range(1, line_chars.size() - 2)) void'(line_chars.pop_back());
    end else if (r >= 90) begin
      add_trailing($urandom_range(1, 8));
    end
    send_line();
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int ph;
    int target;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 3'd0;
    pwdata        <= 32'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines run with the reset configuration.
    run_directed();
    wait_drained();

    // Random phases, each under its own configuration.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(RegMinLineChars, 8'd0);
          write_reg(RegMaxDataBytes, 8'd1);
          hold_go = 1'b1;
        end
        1: begin
          write_reg(RegMinLineChars, 8'd255);
          write_reg(RegMaxDataBytes, 8'd252);
          build_record("1", $urandom, 252, -1, 8'h00, 1'b1);
          send_line();
        end
        2: begin
          write_reg(RegMinLineChars, 8'($urandom_range(0, 40)));
          write_reg(RegMaxDataBytes, 8'($urandom_range(1, 20)));
        end
        default: begin
          write_reg(RegMinLineChars, 8'($urandom_range(0, 20)));
          write_reg(RegMaxDataBytes, 8'($urandom_range(16, 252)));
        end
      endcase
      target = chars_sent + PhaseChars;
      while (chars_sent < target) random_line();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/srlp_pkg.sv
hdl/srlp_apb_regs.sv
hdl/srlp_parse_core.sv
hdl/srlp_out_stage.sv
hdl/srecord_line_parser_unit.sv
hdl/srlp_checker.sv
tb/sv/srlp_result_checker.sv
tb/sv/tb_srecord_line_parser_unit.sv
